// ----- src/assert_macros.svh -----
// assertion macros used by the checker file svn_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted (active low)
`define SVN_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// clocked assertion that also holds during reset
`define SVN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- src/svn_pkg.sv -----
// widths and constants of the stretched value noise block
// no dependencies
package svn_pkg;

  // item fields and configuration
  localparam int LEVEL_W  = 15;
  localparam int LEN_W    = 13;
  localparam int SAMPLE_W = 16;

  // fixed point format of position and step
  localparam int FRAC_BITS   = 24;
  localparam int MAX_SEGMENT = 4096;
  localparam int POS_W       = FRAC_BITS + 2;
  localparam int LEVEL_SHIFT = FRAC_BITS - LEVEL_W;

  // shaping datapath, t is held in Q24 with one integer bit
  localparam int T_W    = 25;
  localparam int P_W    = 28;
  localparam int PROD_W = P_W + T_W;
  localparam int SS_W   = PROD_W - 24;

  // restoring divider
  localparam int DIV_W     = 31;
  localparam int REM_W     = LEN_W;
  localparam int CNT_W     = 5;
  localparam int STEP_ITER = LEVEL_W + LEVEL_SHIFT;

  // constants of the shaping curve
  localparam int SCALE_DEN  = 99;
  localparam int HALF_LEVEL = 16384;
  localparam int LEN_RESET  = 64;

  // pos*100/99 is pos + pos/99; pos/99 by reciprocal, exact for pos below 2^25
  localparam int     RECIP_SHIFT = 32;
  localparam longint T_RECIP     =
    ((longint'(1) << RECIP_SHIFT) + longint'(SCALE_DEN) - 1) / longint'(SCALE_DEN);

endpackage

// ----- src/svn_in_if.sv -----
// input channel of the stretched value noise block: one random level per item
// depends on svn_pkg
interface svn_in_if;
  import svn_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] random_level;

  modport source (output valid, output random_level, input ready);
  modport sink   (input valid, input random_level, output ready);
endinterface

// ----- src/svn_out_if.sv -----
// output channel of the stretched value noise block: one sample per item
// depends on svn_pkg
interface svn_out_if;
  import svn_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       segment_start;

  modport source (output valid, output sample, output segment_start, input ready);
  modport sink   (input valid, input sample, input segment_start, output ready);
endinterface

// ----- src/stretched_value_noise.sv -----
// stretched value noise: linear segments between random levels, shaped by smootherstep
// depends on svn_pkg, svn_in_if, svn_out_if
//
//   channel   dir   handshake      payload
//   in_i      in    valid/ready    random_level[14:0]
//   out_o     out   valid/ready    sample[15:0] signed, segment_start
//   cfg       in    cfg_we_i       cfg_wdata_i[12:0] = stretch_length
//
// a segment-start item runs the 24-step divide of the step size on the restoring
// divider (S_SDIV, S_SFIX) before the shaping steps that a stepping item runs alone;
// the shared multiplier is used in four steps (1/99, t^2, t^3, p*t^3)
// reset sets stretch_length 64, the end level to one half, position and step 0
// a finished sample waits in the output register; a new item is taken meanwhile,
// and a second finished sample stalls in the last step until the output is free
module stretched_value_noise (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  svn_in_if.sink                     in_i,
  svn_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [svn_pkg::LEN_W-1:0]  cfg_wdata_i
);
  import svn_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SDIV  = 10'b00_0000_0010,
    S_SFIX  = 10'b00_0000_0100,
    S_TLOAD = 10'b00_0000_1000,
    S_TSAT  = 10'b00_0001_0000,
    S_SQ    = 10'b00_0010_0000,
    S_CUBE  = 10'b00_0100_0000,
    S_POLY  = 10'b00_1000_0000,
    S_MUL3  = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_e;

  localparam logic [T_W-1:0]   T_ONE = T_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // control and architectural state
  state_e                     state_q, state_d;
  logic [LEN_W-1:0]           cfg_len_q, cfg_len_d;
  logic [LEN_W-1:0]           tick_q, tick_d;
  logic [LEVEL_W-1:0]         end_q, end_d;
  logic signed [POS_W-1:0]    step_q, step_d;
  logic signed [POS_W-1:0]    pos_q, pos_d;
  logic                       out_valid_q, out_valid_d;

  // datapath registers
  logic [DIV_W-1:0]           dq_q, dq_d;
  logic [REM_W-1:0]           dr_q, dr_d;
  logic [REM_W-1:0]           dd_q, dd_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       neg_q, neg_d;
  logic                       seg_q, seg_d;
  logic [T_W-1:0]             t_q, t_d;
  logic [T_W-1:0]             t2_q, t2_d;
  logic [T_W-1:0]             t3_q, t3_d;
  logic [P_W-1:0]             p_q, p_d;
  logic [PROD_W-1:0]          prod_q, prod_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic                       seg_out_q, seg_out_d;

  // effective segment length and divisor of the step
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] step_div;
  assign len      = (cfg_len_q > LEN_W'(MAX_SEGMENT)) ? LEN_W'(MAX_SEGMENT) : cfg_len_q;
  assign step_div = (len == '0) ? LEN_W'(1) : len;

  // saturating position update
  logic [POS_W:0]   pos_sum;
  logic [POS_W-1:0] pos_sat;
  assign pos_sum = {pos_q[POS_W-1], pos_q} + {step_q[POS_W-1], step_q};
  always_comb begin
    if (pos_sum[POS_W] != pos_sum[POS_W-1]) begin
      pos_sat = pos_sum[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      pos_sat = pos_sum[POS_W-1:0];
    end
  end

  // level difference of a new segment, sign and magnitude
  logic [LEVEL_W:0]   lvl_diff;
  logic [LEVEL_W-1:0] lvl_mag;
  assign lvl_diff = {1'b0, in_i.random_level} - {1'b0, end_q};
  assign lvl_mag  = lvl_diff[LEVEL_W] ? LEVEL_W'(-lvl_diff) : lvl_diff[LEVEL_W-1:0];

  // position clamped to [0, 1] for the shaping curve
  logic [T_W-1:0] pos_clamp;
  always_comb begin
    if (pos_q[POS_W-1]) begin
      pos_clamp = '0;
    end else if (pos_q[POS_W-2:0] > (POS_W-1)'(T_ONE)) begin
      pos_clamp = T_ONE;
    end else begin
      pos_clamp = pos_q[T_W-1:0];
    end
  end

  // stretched t: clamped position plus its ninety-ninth part
  logic [T_W-1:0] t_quot;
  logic [T_W-1:0] t_sum;
  assign t_quot = T_W'(prod_q[PROD_W-1:RECIP_SHIFT]);
  assign t_sum  = pos_clamp + t_quot;

  // restoring divider: one restoring step per cycle
  logic [REM_W:0]   div_rs;
  logic [REM_W:0]   div_diff;
  logic             div_ge;
  logic [DIV_W-1:0] div_q_next;
  logic [REM_W-1:0] div_r_next;
  assign div_rs     = {dr_q, dq_q[DIV_W-1]};
  assign div_diff   = div_rs - {1'b0, dd_q};
  assign div_ge     = div_rs >= {1'b0, dd_q};
  assign div_q_next = {dq_q[DIV_W-2:0], div_ge};
  assign div_r_next = div_ge ? div_diff[REM_W-1:0] : div_rs[REM_W-1:0];

  // shared multiplier, operands picked by the sequencer
  logic [P_W-1:0]    mul_a;
  logic [T_W-1:0]    mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [T_W-1:0]    prod_hi;
  assign prod_hi = prod_q[FRAC_BITS+T_W-1:FRAC_BITS];
  always_comb begin
    mul_a = p_q;
    mul_b = t3_q;
    if (state_q == S_TLOAD) begin
      mul_a = P_W'(T_RECIP);
      mul_b = pos_clamp;
    end else if (state_q == S_SQ) begin
      mul_a = P_W'(t_q);
      mul_b = t_q;
    end else if (state_q == S_CUBE) begin
      mul_a = P_W'(prod_hi);
      mul_b = t_q;
    end
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // polynomial 6t^2 - 15t + 10, clamped at zero
  logic signed [DIV_W-1:0] poly;
  assign poly = $signed(DIV_W'(t2_q) << 2) + $signed(DIV_W'(t2_q) << 1)
              - $signed(DIV_W'(t_q) << 4) + $signed(DIV_W'(t_q))
              + $signed(DIV_W'(10) << FRAC_BITS);

  // final sample from the shaped value
  logic [SS_W-1:0]           ss;
  logic signed [SS_W-7:0]    s_full;
  assign ss     = prod_q[PROD_W-1:FRAC_BITS];
  assign s_full = $signed({1'b0, ss[SS_W-1:8]}) - $signed((SS_W-6)'(32768));

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.sample        = sample_q;
  assign out_o.segment_start = seg_out_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cfg_len_d   = cfg_len_q;
    tick_d      = tick_q;
    end_d       = end_q;
    step_d      = step_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    dq_d        = dq_q;
    dr_d        = dr_q;
    dd_d        = dd_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    seg_d       = seg_q;
    t_d         = t_q;
    t2_d        = t2_q;
    t3_d        = t3_q;
    p_d         = p_q;
    prod_d      = prod_q;
    sample_d    = sample_q;
    seg_out_d   = seg_out_q;

    if (cfg_we_i) begin
      cfg_len_d = cfg_wdata_i;
    end
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (tick_q < len) begin
            pos_d   = pos_sat;
            tick_d  = tick_q + LEN_W'(1);
            seg_d   = 1'b0;
            state_d = S_TLOAD;
          end else begin
            tick_d  = '0;
            pos_d   = $signed(POS_W'(end_q) << LEVEL_SHIFT);
            end_d   = in_i.random_level;
            neg_d   = lvl_diff[LEVEL_W];
            dq_d    = DIV_W'(lvl_mag) << (DIV_W - LEVEL_W);
            dr_d    = '0;
            dd_d    = step_div;
            cnt_d   = CNT_W'(STEP_ITER - 1);
            seg_d   = 1'b1;
            state_d = S_SDIV;
          end
        end
      end
      S_SDIV: begin
        dq_d  = div_q_next;
        dr_d  = div_r_next;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_SFIX;
        end
      end
      S_SFIX: begin
        // quotient truncated toward zero, sign applied afterwards
        step_d  = neg_q ? -$signed(POS_W'(dq_q[STEP_ITER-1:0]))
                        : $signed(POS_W'(dq_q[STEP_ITER-1:0]));
        state_d = S_TLOAD;
      end
      S_TLOAD: begin
        // position times the reciprocal of 99
        prod_d  = mul_p;
        state_d = S_TSAT;
      end
      S_TSAT: begin
        t_d     = (t_sum > T_ONE) ? T_ONE : t_sum;
        state_d = S_SQ;
      end
      S_SQ: begin
        prod_d  = mul_p;
        state_d = S_CUBE;
      end
      S_CUBE: begin
        t2_d    = prod_hi;
        prod_d  = mul_p;
        state_d = S_POLY;
      end
      S_POLY: begin
        t3_d    = prod_hi;
        p_d     = poly[DIV_W-1] ? '0 : poly[P_W-1:0];
        state_d = S_MUL3;
      end
      S_MUL3: begin
        prod_d  = mul_p;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          sample_d    = (s_full > $signed((SS_W-6)'(32767))) ? SAMPLE_W'(32767)
                                                            : s_full[SAMPLE_W-1:0];
          seg_out_d   = seg_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and architectural state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_len_q   <= LEN_W'(LEN_RESET);
      tick_q      <= '0;
      end_q       <= LEVEL_W'(HALF_LEVEL);
      step_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_len_q   <= cfg_len_d;
      tick_q      <= tick_d;
      end_q       <= end_d;
      step_q      <= step_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dq_q      <= dq_d;
    dr_q      <= dr_d;
    dd_q      <= dd_d;
    cnt_q     <= cnt_d;
    neg_q     <= neg_d;
    seg_q     <= seg_d;
    t_q       <= t_d;
    t2_q      <= t2_d;
    t3_q      <= t3_d;
    p_q       <= p_d;
    prod_q    <= prod_d;
    sample_q  <= sample_d;
    seg_out_q <= seg_out_d;
  end

endmodule

// ----- src/svn_checker.sv -----
// port-level checks of the stretched value noise block, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module svn_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // items accepted whose sample has not been taken yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  `SVN_ASSERT_RST(a_busy_after_accept, clk_i, rst_ni, in_acc |=> !in_ready_i, "input ready right after an accepted item")
  `SVN_ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "stalled sample dropped")
  `SVN_ASSERT_RST(a_no_extra_result, clk_i, rst_ni, out_valid_i |-> pend_q != 2'd0, "sample shown with no item outstanding")
  `SVN_ASSERT_RST(a_pend_bound, clk_i, rst_ni, pend_q != 2'd3, "more than two items outstanding")
  `SVN_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i, "output valid during reset")

endmodule

bind stretched_value_noise svn_checker u_svn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);

// ----- bench/stretched_value_noise_test.sv -----
// testbench for stretched_value_noise: directed rows, then random phases of levels
// checks every sample against a fixed-point smootherstep predictor kept in this file or a row's typed value
// depends on svn_pkg, svn_in_if, svn_out_if and the stretched_value_noise rtl
module stretched_value_noise_test;
  timeunit 1ns;
  timeprecision 1ps;
  import svn_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int STALL_CYCLES = 400;
  localparam int TAIL_CYCLES  = 100;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 120;
  localparam int DIRECTED_N   = 21;

  // shaping constants: t is held in Q24, position scaled by 100/99
  localparam int     T_FRAC      = 24;
  localparam longint STRETCH_NUM = 100;
  localparam longint STRETCH_DEN = 99;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -32768;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32767;
  localparam logic [LEVEL_W-1:0]         LEVEL_TOP  = '1;
  localparam logic [LEN_W-1:0]           LEN_TOP    = '1;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       segment_start;
  } noise_sample_t;

  typedef struct {
    bit                         write_len;
    logic [LEN_W-1:0]           len;
    logic [LEVEL_W-1:0]         level;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       segment_start;
  } directed_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [LEN_W-1:0] cfg_wdata_i;

  svn_in_if  in_ch ();
  svn_out_if out_ch ();

  stretched_value_noise u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predictor state, mirrors the block after reset
  logic [LEN_W-1:0]   stretch_len = LEN_W'(LEN_RESET);
  int unsigned        seg_ticks   = 0;
  logic [LEVEL_W-1:0] seg_from    = LEVEL_W'(HALF_LEVEL);
  logic [LEVEL_W-1:0] seg_to      = LEVEL_W'(HALF_LEVEL);
  longint             seg_step    = 0;
  longint             seg_pos     = 0;

  noise_sample_t noise_expect_q[$];

  int errors        = 0;
  int levels_sent   = 0;
  int samples_seen  = 0;
  int seg_starts    = 0;
  int cfg_writes    = 0;
  int stalls_done   = 0;
  int cycle_count   = 0;
  int src_idle_pct  = 22;
  int sink_idle_pct = 70;
  int hold_left     = 0;
  bit sink_hold_req = 1'b0;

  // directed rows: reset state, zero length, length one, long length,
  // length cut below the running tick count
  directed_row_t directed_rows [DIRECTED_N] = '{
    '{1'b0, 13'd0,    LEVEL_TOP,  1'b1, SAMPLE_MIN, 1'b0},
    '{1'b0, 13'd0,    15'h0000,   1'b1, SAMPLE_MIN, 1'b0},
    '{1'b1, 13'd0,    LEVEL_TOP,  1'b0, SAMPLE_MIN, 1'b0},
    '{1'b0, 13'd0,    15'h0000,   1'b1, SAMPLE_MAX, 1'b1},
    '{1'b0, 13'd0,    LEVEL_TOP,  1'b1, SAMPLE_MIN, 1'b1},
    '{1'b0, 13'd0,    15'h5555,   1'b1, SAMPLE_MAX, 1'b1},
    '{1'b0, 13'd0,    15'h2AAA,   1'b0, SAMPLE_MIN, 1'b0},
    '{1'b0, 13'd0,    15'h0000,   1'b0, SAMPLE_MIN, 1'b0},
    '{1'b1, 13'd1,    LEVEL_TOP,  1'b0, SAMPLE_MIN, 1'b0},
    '{1'b0, 13'd0,    LEVEL_TOP,  1'b1, SAMPLE_MIN, 1'b1},
    '{1'b0, 13'd0,    15'h0000,   1'b0, SAMPLE_MIN, 1'b0},
    '{1'b1, LEN_TOP,  15'h0000,   1'b1, SAMPLE_MAX, 1'b0},
    '{1'b0, 13'd0,    15'h0000,   1'b1, SAMPLE_MAX, 1'b0},
    '{1'b0, 13'd0,    15'h1234,   1'b1, SAMPLE_MAX, 1'b0},
    '{1'b1, 13'd2,    15'h4000,   1'b1, SAMPLE_MAX, 1'b1},
    '{1'b0, 13'd0,    15'h0001,   1'b0, SAMPLE_MIN, 1'b0},
    '{1'b0, 13'd0,    15'h7FFE,   1'b0, SAMPLE_MIN, 1'b0},
    '{1'b0, 13'd0,    LEVEL_TOP,  1'b0, SAMPLE_MIN, 1'b0},
    '{1'b1, 13'd4097, 15'h0000,   1'b0, SAMPLE_MIN, 1'b0},
    '{1'b1, 13'd4096, 15'h6000,   1'b0, SAMPLE_MIN, 1'b0},
    '{1'b1, 13'd3,    15'h1357,   1'b0, SAMPLE_MIN, 1'b0}
  };

  // clock and single reset
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint level_pos(logic [LEVEL_W-1:0] lvl);
    return longint'(lvl) <<< LEVEL_SHIFT;
  endfunction

  // 6t^5 - 15t^4 + 10t^3 over the clamped, stretched position
  function automatic logic signed [SAMPLE_W-1:0] smootherstep_sample(longint pos);
    longint one_q, t, t2, t3, poly, ss, s;
    one_q = longint'(1) <<< FRAC_BITS;
    if (pos < 0) pos = 0;
    if (pos > one_q) pos = one_q;
    t = ((pos * STRETCH_NUM) / STRETCH_DEN) <<< (T_FRAC - FRAC_BITS);
    if (t > (longint'(1) <<< T_FRAC)) t = longint'(1) <<< T_FRAC;
    t2 = (t * t) >>> T_FRAC;
    t3 = (t2 * t) >>> T_FRAC;
    poly = 6 * t2 + 10 * (longint'(1) <<< T_FRAC) - 15 * t;
    if (poly < 0) poly = 0;
    ss = (poly * t3) >>> T_FRAC;
    s = (ss >>> 8) - 32768;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return SAMPLE_W'(s);
  endfunction

  // advances the segment state by one tick and gives the sample it produces
  function automatic noise_sample_t next_noise_sample(logic [LEVEL_W-1:0] lvl);
    int unsigned   len_eff;
    longint        divisor, lim;
    noise_sample_t r;
    len_eff = stretch_len;
    if (len_eff > MAX_SEGMENT) len_eff = MAX_SEGMENT;
    lim = longint'(1) <<< (FRAC_BITS + 1);
    if (seg_ticks < len_eff) begin
      seg_pos = seg_pos + seg_step;
      if (seg_pos > lim - 1) seg_pos = lim - 1;
      if (seg_pos < -lim) seg_pos = -lim;
      seg_ticks++;
      r.segment_start = 1'b0;
    end else begin
      divisor = (len_eff == 0) ? 1 : longint'(len_eff);
      seg_ticks = 0;
      seg_from = seg_to;
      seg_pos = level_pos(seg_from);
      seg_to = lvl;
      seg_step = (level_pos(seg_to) - level_pos(seg_from)) / divisor;
      r.segment_start = 1'b1;
    end
    r.sample = smootherstep_sample(seg_pos);
    return r;
  endfunction

  // offer one level, idling first at random, and record what it should give
  task automatic send_level(logic [LEVEL_W-1:0] lvl, bit typed,
                            noise_sample_t typed_exp);
    noise_sample_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.random_level <= lvl;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predicted = next_noise_sample(lvl);
    noise_expect_q.push_back(typed ? typed_exp : predicted);
    levels_sent++;
  endtask

  // stop offering and wait until every expected sample is back
  task automatic drain_samples();
    in_ch.valid <= 1'b0;
    while (noise_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_stretch(logic [LEN_W-1:0] len);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    stretch_len = len;
    cfg_writes++;
  endtask

  // receiver: random ready, long hold-off on request, checks every sample
  always @(posedge clk_i or negedge rst_ni) begin : sample_sink
    noise_sample_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        samples_seen++;
        if (out_ch.segment_start === 1'b1) seg_starts++;
        if (noise_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, sample %0d segment_start %0b", $time,
                   out_ch.sample, out_ch.segment_start);
        end else begin
          want = noise_expect_q.pop_front();
          if (out_ch.sample !== want.sample) begin
            errors++;
            $display("%0t: sample expected %0d actual %0d", $time, want.sample,
                     out_ch.sample);
          end
          if (out_ch.segment_start !== want.segment_start) begin
            errors++;
            $display("%0t: segment_start expected %0b actual %0b", $time,
                     want.segment_start, out_ch.segment_start);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        hold_left = STALL_CYCLES;
        stalls_done++;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // main sequence
  initial begin : stimulus
    noise_sample_t     row_exp;
    logic [LEN_W-1:0]  len;
    logic [LEVEL_W-1:0] lvl;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.random_level = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    for (int i = 0; i < DIRECTED_N; i++) begin
      if (directed_rows[i].write_len) begin
        drain_samples();
        write_stretch(directed_rows[i].len);
      end
      row_exp.sample = directed_rows[i].sample;
      row_exp.segment_start = directed_rows[i].segment_start;
      send_level(directed_rows[i].level, directed_rows[i].typed, row_exp);
    end

    // random phases, each with its own stretch length, and an idling mix per group of four
    for (int p = 0; p < PHASES; p++) begin
      drain_samples();
      if (p < 4) begin
        src_idle_pct = 22;
        sink_idle_pct = 70;
      end else if (p < 8) begin
        src_idle_pct = 70;
        sink_idle_pct = 22;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      case ($urandom_range(0, 9))
        0:             len = '0;
        1, 2, 3, 4, 5: len = LEN_W'($urandom_range(1, 16));
        6:             len = LEN_W'($urandom_range(17, 300));
        7:             len = LEN_W'(MAX_SEGMENT);
        8:             len = LEN_TOP;
        default:       len = LEN_W'($urandom_range(0, 8191));
      endcase
      write_stretch(len);
      // long output hold-off so the block backs up into its input
      if (p == 1) begin
        @(negedge clk_i);
        sink_hold_req = 1'b1;
        @(posedge clk_i);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) == 0)
          lvl = $urandom_range(0, 1) ? LEVEL_TOP : '0;
        else
          lvl = LEVEL_W'($urandom_range(0, 32767));
        send_level(lvl, 1'b0, row_exp);
      end
    end

    // wind down and look for stray samples
    drain_samples();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (noise_expect_q.size() != 0) begin
      errors++;
      $display("%0t: %0d samples never arrived", $time, noise_expect_q.size());
    end
    $display("summary: %0d levels sent, %0d samples checked, %0d segment starts",
             levels_sent, samples_seen, seg_starts);
    $display("summary: %0d length writes, %0d long output stalls, %0d errors",
             cfg_writes, stalls_done, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
